>>> rtl/core/cssamd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cssamd_pkg;

  // Pipeline control that the top level hands to each arithmetic unit.
  typedef struct packed {
    logic advance;  // every stage moves one step
    logic valid;    // a request enters the first stage
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/cssamd_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module cssamd_mul #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned LATENCY    = 32
) (
  input  wire logic                      clk_i,
  input  wire cssamd_pkg::pipe_ctl_t     ctl_i,
  input  wire logic [DATA_WIDTH-1:0]     mag_a_i,
  input  wire logic [DATA_WIDTH-1:0]     mag_b_i,
  output logic      [2*DATA_WIDTH-1:0]   prod_o
);

  localparam int unsigned HW = (DATA_WIDTH + 1) / 2;
  localparam int unsigned PW = 2 * DATA_WIDTH;

  logic [HW-1:0]   a_lo, a_hi, b_lo, b_hi;
  logic [2*HW-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [PW-1:0]   full;
  logic [PW-1:0]   dly_q [LATENCY-1];

  // Split each operand into two halves so no single multiplier exceeds
  // half the operand width.
  assign a_lo = mag_a_i[HW-1:0];
  assign b_lo = mag_b_i[HW-1:0];
  assign a_hi = HW'(mag_a_i >> HW);
  assign b_hi = HW'(mag_b_i >> HW);

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      pp00_q <= a_lo * b_lo;
      pp01_q <= a_lo * b_hi;
      pp10_q <= a_hi * b_lo;
      pp11_q <= a_hi * b_hi;
    end
  end

  assign full = PW'(pp00_q) + (PW'(pp01_q) << HW) + (PW'(pp10_q) << HW)
              + (PW'(pp11_q) << (2 * HW));

  // The product waits here until the quotient of the same request is done.
  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      dly_q[0] <= full;
      for (int i = 1; i < LATENCY - 1; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign prod_o = dly_q[LATENCY-2];

endmodule

`default_nettype wire

>>> rtl/core/cssamd_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cssamd_div #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned TAG_WIDTH  = 36
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cssamd_pkg::pipe_ctl_t  ctl_i,
  input  wire logic [DATA_WIDTH-1:0]  dividend_i,
  input  wire logic [DATA_WIDTH-1:0]  divisor_i,
  input  wire logic [TAG_WIDTH-1:0]   tag_i,
  output logic      [DATA_WIDTH-1:0]  quot_o,
  output logic      [TAG_WIDTH-1:0]   tag_o,
  output logic                        valid_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0]         rem_q [W];
  logic [W-1:0]         num_q [W];
  logic [W-1:0]         den_q [W];
  logic [TAG_WIDTH-1:0] tag_q [W];
  logic [W-1:0]         vld_q;

  // One restoring step per stage: the numerator shifts out at the top while
  // the quotient bits shift in at the bottom.
  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0] rem_prev, num_prev, den_prev;
    logic [W:0]   trial, diff;
    logic         fits;

    if (i == 0) begin : g_first
      assign rem_prev = '0;
      assign num_prev = dividend_i;
      assign den_prev = divisor_i;
    end else begin : g_next
      assign rem_prev = rem_q[i-1];
      assign num_prev = num_q[i-1];
      assign den_prev = den_q[i-1];
    end

    assign trial = {rem_prev, num_prev[W-1]};
    assign diff  = trial - {1'b0, den_prev};
    assign fits  = trial >= {1'b0, den_prev};

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        rem_q[i] <= fits ? diff[W-1:0] : trial[W-1:0];
        num_q[i] <= {num_prev[W-2:0], fits};
        den_q[i] <= den_prev;
        tag_q[i] <= (i == 0) ? tag_i : tag_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.advance) begin
      vld_q <= {vld_q[W-2:0], ctl_i.valid};
    end
  end

  assign quot_o  = num_q[W-1];
  assign tag_o   = tag_q[W-1];
  assign valid_o = vld_q[W-1];

endmodule

`default_nettype wire

>>> rtl/core/checked_signed_add_mul_div_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  operand_a, operand_b
// m_axis    out        m_axis_tvalid/m_axis_tready  sum, product, quotient with flags
//
// A request passes the input register, the divider stages and the output
// register; one request enters every cycle unless the output stalls. The divider
// sets the depth, one quotient bit per stage; sum and product travel alongside it.
// Reset clears only the valid bits of the stages and the output register.
// When the output register is full and not taken, every stage holds.

module checked_signed_add_mul_div_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // operand_a, operand_b
  input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // sum_value, sum_valid, product_value, product_valid,
  // quotient_value, quotient_valid
  output logic      [((3*DATA_WIDTH+3+7)/8)*8-1:0]     m_axis_tdata
);

  localparam int unsigned W      = DATA_WIDTH;
  localparam int unsigned OUT_W  = ((3 * W + 3 + 7) / 8) * 8;
  // Tag layout: sum_value, sum_valid, sign_diff, quot_ok.
  localparam int unsigned TAG_W  = W + 3;

  cssamd_pkg::pipe_ctl_t ctl;
  logic                  advance;

  logic [W-1:0] op_a, op_b, mag_a, mag_b, sum;
  logic         neg_a, neg_b, sum_ok, quot_ok;
  logic [W-1:0] mag_a_q, mag_b_q;
  logic [TAG_W-1:0] tag_q;
  logic         vld1_q;

  logic [2*W-1:0]   prod;
  logic [W-1:0]     quot;
  logic [TAG_W-1:0] tag_end;
  logic             vld_end;

  logic [W-1:0] prod_lo, prod_val, quot_val, sum_val;
  logic         prod_ok, sign_diff, quot_ok_end, sum_ok_end;

  logic [OUT_W-1:0] out_data_q;
  logic             out_valid_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  assign op_a  = s_axis_tdata[W-1:0];
  assign op_b  = s_axis_tdata[2*W-1:W];
  assign neg_a = op_a[W-1];
  assign neg_b = op_b[W-1];
  // The negated minimum is its own pattern, which is the right magnitude.
  assign mag_a = neg_a ? (~op_a + 1'b1) : op_a;
  assign mag_b = neg_b ? (~op_b + 1'b1) : op_b;
  assign sum   = op_a + op_b;
  assign sum_ok = !((neg_a == neg_b) && (sum[W-1] != neg_a));
  assign quot_ok = (op_b != '0)
                && !((op_a == {1'b1, {(W-1){1'b0}}}) && (op_b == {W{1'b1}}));

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mag_a_q <= mag_a;
      mag_b_q <= mag_b;
      tag_q   <= {quot_ok, neg_a ^ neg_b, sum_ok, sum_ok ? sum : {W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (advance) begin
      vld1_q <= s_axis_tvalid;
    end
  end

  assign ctl.advance = advance;
  assign ctl.valid   = vld1_q;

  cssamd_mul #(
    .DATA_WIDTH (W),
    .LATENCY    (W)
  ) u_mul (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .mag_a_i (mag_a_q),
    .mag_b_i (mag_b_q),
    .prod_o  (prod)
  );

  cssamd_div #(
    .DATA_WIDTH (W),
    .TAG_WIDTH  (TAG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .dividend_i (mag_a_q),
    .divisor_i  (mag_b_q),
    .tag_i      (tag_q),
    .quot_o     (quot),
    .tag_o      (tag_end),
    .valid_o    (vld_end)
  );

  assign sum_val     = tag_end[W-1:0];
  assign sum_ok_end  = tag_end[W];
  assign sign_diff   = tag_end[W+1];
  assign quot_ok_end = tag_end[W+2];

  // A negative product may reach exactly the minimum; a positive one may not.
  assign prod_lo  = prod[W-1:0];
  assign prod_ok  = (prod[2*W-1:W] == '0)
                 && (!prod_lo[W-1] || (sign_diff && (prod_lo[W-2:0] == '0)));
  assign prod_val = !prod_ok ? '0 : (sign_diff ? (~prod_lo + 1'b1) : prod_lo);
  assign quot_val = !quot_ok_end ? '0 : (sign_diff ? (~quot + 1'b1) : quot);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= OUT_W'({quot_ok_end, quot_val, prod_ok, prod_val,
                            sum_ok_end, sum_val});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= vld_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // An overflowed sum must read as zero.
  a_sum_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[W] |-> m_axis_tdata[W-1:0] == '0)
    else $error("sum not cleared on overflow");

  // An invalid quotient must read as zero.
  a_quot_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3*W+2] |-> m_axis_tdata[3*W+1:2*W+2] == '0)
    else $error("quotient not cleared when invalid");

  // Sum overflow means equal operand signs, so a valid quotient of the same
  // request is not negative; this catches lanes drifting out of step.
  a_lane_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[W] && m_axis_tdata[3*W+2]
      |-> !m_axis_tdata[3*W+1])
    else $error("sum and quotient lanes out of step");

  // A result appears only after a request entered the pipeline.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_end))
    else $error("result without a request");

endmodule

`default_nettype wire
